/* design/lbs_pkg.sv */
// Package for the LED blink sequencer.
// Holds the item kind codes, the result struct and the parameter defaults.
// No dependencies.
package lbs_pkg;

  localparam int unsigned TIME_BITS_DEFAULT  = 16;
  localparam int unsigned COUNT_BITS_DEFAULT = 16;
  localparam int unsigned COLOR_BITS         = 24;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_STATIC = 2'd1,
    KIND_BLINK  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] drive_color;
    logic                  blinking;
  } result_t;

endpackage

/* design/led_blink_sequencer.sv */
// Top level of the LED blink sequencer: input register, state update, result register.
// Depends on lbs_pkg and lbs_state.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  input   | in_valid / in_stall   | kind, new_color, blink_period, on_time,
//          |                       | blink_count
//  output  | out_valid / out_stall | drive_color, blinking
//
// One item per cycle sustained while out_stall stays low; each item yields one
// result, passing through the input register, then the result register.
// The state registers update when an item leaves the input register, so the
// result shows the state after that item.
// rst is synchronous: static mode, LED off, both stages empty.
// A stalled result holds the result register; the input register still takes
// one more item, after which in_stall rises.
module led_blink_sequencer #(
  parameter int unsigned TIME_BITS  = lbs_pkg::TIME_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS = lbs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     kind,
  input  logic [lbs_pkg::COLOR_BITS-1:0] new_color,
  input  logic [TIME_BITS-1:0]           blink_period,
  input  logic [TIME_BITS-1:0]           on_time,
  input  logic [COUNT_BITS-1:0]          blink_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lbs_pkg::COLOR_BITS-1:0] drive_color,
  output logic                           blinking
);

  // input register
  logic                           stage_valid;
  logic [1:0]                     stage_kind;
  logic [lbs_pkg::COLOR_BITS-1:0] stage_color;
  logic [TIME_BITS-1:0]           stage_period;
  logic [TIME_BITS-1:0]           stage_on;
  logic [COUNT_BITS-1:0]          stage_count;

  logic             advance;   // result register can take a new item
  logic             step;      // item moves from input reg to result reg
  logic             accept;
  lbs_pkg::result_t result;

  assign advance  = !out_valid || !out_stall;
  assign step     = stage_valid && advance;
  assign in_stall = stage_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept || (stage_valid && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_kind   <= kind;
      stage_color  <= new_color;
      stage_period <= blink_period;
      stage_on     <= on_time;
      stage_count  <= blink_count;
    end
  end

  lbs_state #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .kind         (stage_kind),
    .new_color    (stage_color),
    .blink_period (stage_period),
    .on_time      (stage_on),
    .blink_count  (stage_count),
    .result       (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= step || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      drive_color <= result.drive_color;
      blinking    <= result.blinking;
    end
  end

  // an empty result register never holds back the input side
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("in_stall high with empty result register");

  // a new result only comes from an item held in the input register
  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(stage_valid))
    else $error("result appeared without a staged item");

  // a set-static item always ends a blink run
  a_static_clears_blink: assert property (@(posedge clk) disable iff (rst)
    (step && stage_kind == lbs_pkg::KIND_STATIC) |=> !blinking)
    else $error("blinking still set after set-static item");

endmodule

/* design/lbs_state.sv */
// Blink state registers and the per-item update logic.
// Depends on lbs_pkg. Produces the result of the item being applied.
module lbs_state #(
  parameter int unsigned TIME_BITS  = lbs_pkg::TIME_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS = lbs_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [1:0]                      kind,
  input  logic [lbs_pkg::COLOR_BITS-1:0]  new_color,
  input  logic [TIME_BITS-1:0]            blink_period,
  input  logic [TIME_BITS-1:0]            on_time,
  input  logic [COUNT_BITS-1:0]           blink_count,
  output lbs_pkg::result_t                result
);

  logic                           in_blink_mode, in_blink_mode_next;
  logic                           lit_phase, lit_phase_next;
  logic [TIME_BITS-1:0]           phase_ticks_left, phase_ticks_left_next;
  logic [COUNT_BITS-1:0]          blinks_left, blinks_left_next;
  logic                           run_forever, run_forever_next;
  logic [lbs_pkg::COLOR_BITS-1:0] held_color, held_color_next;
  logic [TIME_BITS-1:0]           held_period, held_period_next;
  logic [TIME_BITS-1:0]           held_on_time, held_on_time_next;

  logic [TIME_BITS-1:0]  on_clamped;
  logic [TIME_BITS-1:0]  gap;
  logic [TIME_BITS-1:0]  lit_len;
  logic [COUNT_BITS-1:0] blinks_dec;

  always_comb begin
    on_clamped = (on_time < blink_period) ? on_time : (blink_period >> 1);
    gap        = (held_period > held_on_time) ? (held_period - held_on_time)
                                              : '0;
    // lit phase lasts at least one tick
    lit_len    = (held_on_time == '0) ? TIME_BITS'(1) : held_on_time;
    blinks_dec = blinks_left - COUNT_BITS'(1);

    in_blink_mode_next    = in_blink_mode;
    lit_phase_next        = lit_phase;
    phase_ticks_left_next = phase_ticks_left;
    blinks_left_next      = blinks_left;
    run_forever_next      = run_forever;
    held_color_next       = held_color;
    held_period_next      = held_period;
    held_on_time_next     = held_on_time;

    case (kind)
      lbs_pkg::KIND_TICK: begin
        if (in_blink_mode) begin
          if (phase_ticks_left > TIME_BITS'(1)) begin
            phase_ticks_left_next = phase_ticks_left - TIME_BITS'(1);
          end else if (lit_phase && !run_forever && blinks_dec == '0) begin
            // last blink done: static, LED off
            in_blink_mode_next    = 1'b0;
            lit_phase_next        = 1'b0;
            phase_ticks_left_next = '0;
            blinks_left_next      = '0;
            run_forever_next      = 1'b0;
            held_color_next       = '0;
          end else if (lit_phase && gap != '0) begin
            if (!run_forever) blinks_left_next = blinks_dec;
            lit_phase_next        = 1'b0;
            phase_ticks_left_next = gap;
          end else begin
            if (lit_phase && !run_forever) blinks_left_next = blinks_dec;
            lit_phase_next        = 1'b1;
            phase_ticks_left_next = lit_len;
          end
        end
      end
      lbs_pkg::KIND_STATIC: begin
        in_blink_mode_next    = 1'b0;
        lit_phase_next        = 1'b0;
        phase_ticks_left_next = '0;
        blinks_left_next      = '0;
        run_forever_next      = 1'b0;
        held_color_next       = new_color;
      end
      lbs_pkg::KIND_BLINK: begin
        held_color_next       = new_color;
        held_period_next      = blink_period;
        held_on_time_next     = on_clamped;
        blinks_left_next      = blink_count;
        run_forever_next      = (blink_count == '0);
        in_blink_mode_next    = 1'b1;
        lit_phase_next        = 1'b1;
        phase_ticks_left_next = (on_clamped == '0) ? TIME_BITS'(1) : on_clamped;
      end
      default: begin
      end
    endcase

    result.blinking    = in_blink_mode_next;
    result.drive_color = (in_blink_mode_next && !lit_phase_next) ? '0
                                                                  : held_color_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_blink_mode    <= 1'b0;
      lit_phase        <= 1'b0;
      phase_ticks_left <= '0;
      blinks_left      <= '0;
      run_forever      <= 1'b0;
      held_color       <= '0;
      held_period      <= '0;
      held_on_time     <= '0;
    end else if (step) begin
      in_blink_mode    <= in_blink_mode_next;
      lit_phase        <= lit_phase_next;
      phase_ticks_left <= phase_ticks_left_next;
      blinks_left      <= blinks_left_next;
      run_forever      <= run_forever_next;
      held_color       <= held_color_next;
      held_period      <= held_period_next;
      held_on_time     <= held_on_time_next;
    end
  end

endmodule
